// ===== src/substring_occurrence_counter_defines.svh =====
// Assertion macros shared by the substring occurrence counter RTL.
// Each macro expects signals named clk and rst in the including scope.
`ifndef SUBSTRING_OCCURRENCE_COUNTER_DEFINES_SVH
`define SUBSTRING_OCCURRENCE_COUNTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SSOC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SSOC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ssoc_pkg.sv =====
// Package for the substring occurrence counter: sizes, opcodes, shared types.
// No dependencies.
package ssoc_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int CHAR_W      = 8;
  localparam int COUNT_W     = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic {
    OP_PATTERN = 1'b0,
    OP_TEXT    = 1'b1
  } opcode_t;

  // Entry 0 holds the newest byte.
  typedef logic [MAX_PATTERN-1:0][CHAR_W-1:0] char_vec_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [CHAR_W-1:0]   char_value;
    logic                last;
  } item_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             truncated;
  } pat_status_t;

endpackage

// ===== src/ssoc_in_if.sv =====
// Input stream channel of the substring occurrence counter.
// Valid/ready handshake with opcode, byte and last flag; depends on ssoc_pkg.
interface ssoc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [ssoc_pkg::CHAR_W-1:0] char_value;
  logic                        last;

  modport source (output valid, output opcode, output char_value, output last,
                  input ready);
  modport sink   (input valid, input opcode, input char_value, input last,
                  output ready);
endinterface

// ===== src/ssoc_out_if.sv =====
// Result channel of the substring occurrence counter.
// Valid/ready handshake with the count and status flags; depends on ssoc_pkg.
interface ssoc_out_if;
  logic                         valid;
  logic                         ready;
  logic [ssoc_pkg::COUNT_W-1:0] match_count;
  logic                         count_saturated;
  logic                         pattern_truncated;

  modport source (output valid, output match_count, output count_saturated,
                  output pattern_truncated, input ready);
  modport sink   (input valid, input match_count, input count_saturated,
                  input pattern_truncated, output ready);
endinterface

// ===== src/ssoc_pattern.sv =====
// Pattern store: shift register of pattern bytes, length, truncation and
// pending-restart flag. Depends on ssoc_pkg.
module ssoc_pattern (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load_en,
  input  logic                      text_en,
  input  logic [ssoc_pkg::CHAR_W-1:0] char_value,
  input  logic                      last,
  output ssoc_pkg::char_vec_t       pat,
  output ssoc_pkg::pat_status_t     status
);
  import ssoc_pkg::*;

  logic [LEN_W-1:0] len, len_next, base_len;
  logic             truncated, truncated_next, base_trunc;
  logic             pending, pending_next;
  logic             room;
  char_vec_t        pat_next;

  // Newest pattern byte sits at entry 0, so entry k lines up with window entry k.
  always_comb begin
    pat_next[0] = char_value;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      pat_next[k] = pat[k-1];
    end
  end

  always_comb begin
    base_len       = pending ? '0 : len;
    base_trunc     = pending ? 1'b0 : truncated;
    room           = (base_len < LEN_W'(MAX_PATTERN));
    len_next       = len;
    truncated_next = truncated;
    pending_next   = pending;
    if (load_en) begin
      len_next       = room ? base_len + 1'b1 : base_len;
      truncated_next = room ? base_trunc : 1'b1;
      pending_next   = last;
    end else if (text_en) begin
      pending_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      truncated <= 1'b0;
      pending   <= 1'b1;
    end else begin
      len       <= len_next;
      truncated <= truncated_next;
      pending   <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en && room) begin
      pat <= pat_next;
    end
  end

  assign status.len       = len;
  assign status.truncated = truncated;

endmodule

// ===== src/ssoc_window.sv =====
// Text window shift register, fill count and parallel compare against the
// stored pattern. Depends on ssoc_pkg.
module ssoc_window (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        shift_en,
  input  logic                        clear,
  input  logic [ssoc_pkg::CHAR_W-1:0] char_value,
  input  ssoc_pkg::char_vec_t         pat,
  input  ssoc_pkg::pat_status_t       status,
  output logic                        hit
);
  import ssoc_pkg::*;

  char_vec_t                window, window_next;
  logic [LEN_W-1:0]         seen, seen_next, seen_inc;
  logic [MAX_PATTERN-1:0]   lane_ok;

  always_comb begin
    window_next[0] = char_value;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      window_next[k] = window[k-1];
    end
  end

  assign seen_inc = (seen < LEN_W'(MAX_PATTERN)) ? seen + 1'b1 : seen;

  // Lanes beyond the pattern length always pass.
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      lane_ok[k] = (LEN_W'(k) >= status.len) || (window_next[k] == pat[k]);
    end
  end

  assign hit = (status.len != '0) && (seen_inc >= status.len) && (&lane_ok);

  // Stale window bytes are never compared: a hit needs seen_inc >= len.
  always_comb begin
    seen_next = seen;
    if (shift_en) begin
      seen_next = clear ? '0 : seen_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else begin
      seen <= seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      window <= window_next;
    end
  end

endmodule

// ===== src/substring_occurrence_counter.sv =====
// Substring occurrence counter. Load a pattern as opcode-0 beats (last closes
// it; bytes past 64 are dropped and flagged), then stream text as opcode-1
// beats. Every text byte is compared against the whole pattern at once, so
// one beat is taken per clock, but a text beat flagged last waits while the
// result register is full and not draining. Its count goes into the result
// register as it leaves the input register, so the input keeps flowing while
// the result waits. The rate is set by the 64-lane byte compare between the
// input and count registers. Overlapping hits count, the count saturates at
// 65535, an empty pattern counts zero, and beats are taken right after reset.
`include "substring_occurrence_counter_defines.svh"

module substring_occurrence_counter (
  input  logic       clk,
  input  logic       rst,
  ssoc_in_if.sink    item,
  ssoc_out_if.source result
);
  import ssoc_pkg::*;

  item_t                s1_item;
  logic                 s1_valid;
  logic                 s1_fire;
  logic                 s1_is_text;
  logic                 s1_result;
  logic                 in_take;
  char_vec_t            pat;
  pat_status_t          pat_st;
  logic                 hit;
  logic [COUNT_W-1:0]   occ_total, occ_total_next, occ_after;
  logic                 res_valid, res_valid_next;
  logic [COUNT_W-1:0]   res_count;
  logic                 res_sat;
  logic                 res_trunc;

  assign s1_is_text = (s1_item.opcode == OP_TEXT);
  assign s1_result  = s1_is_text && s1_item.last;
  // A result beat waits only if the result register is full and not draining.
  assign s1_fire    = s1_valid && !(s1_result && res_valid && !result.ready);
  assign item.ready = !s1_valid || s1_fire;
  assign in_take    = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item.opcode     <= opcode_t'(item.opcode);
      s1_item.char_value <= item.char_value;
      s1_item.last       <= item.last;
    end
  end

  ssoc_pattern u_pattern (
    .clk        (clk),
    .rst        (rst),
    .load_en    (s1_fire && !s1_is_text),
    .text_en    (s1_fire && s1_is_text),
    .char_value (s1_item.char_value),
    .last       (s1_item.last),
    .pat        (pat),
    .status     (pat_st)
  );

  ssoc_window u_window (
    .clk        (clk),
    .rst        (rst),
    .shift_en   (s1_fire && s1_is_text),
    .clear      (s1_item.last),
    .char_value (s1_item.char_value),
    .pat        (pat),
    .status     (pat_st),
    .hit        (hit)
  );

  assign occ_after = (hit && (occ_total != COUNT_MAX)) ? occ_total + 1'b1 : occ_total;

  always_comb begin
    occ_total_next = occ_total;
    if (s1_fire && s1_is_text) begin
      occ_total_next = s1_item.last ? '0 : occ_after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ_total <= '0;
    end else begin
      occ_total <= occ_total_next;
    end
  end

  assign res_valid_next = (res_valid && !result.ready) || (s1_fire && s1_result);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_result) begin
      res_count <= occ_after;
      res_sat   <= (occ_after == COUNT_MAX);
      res_trunc <= pat_st.truncated;
    end
  end

  assign result.valid             = res_valid;
  assign result.match_count       = res_count;
  assign result.count_saturated   = res_sat;
  assign result.pattern_truncated = res_trunc;

  `SSOC_ASSERT_NOW(a_sat_flag, result.valid, result.count_saturated == (result.match_count == COUNT_MAX), "saturation flag disagrees with count")
  `SSOC_ASSERT_NOW(a_len_bound, 1'b1, pat_st.len <= LEN_W'(MAX_PATTERN), "pattern length beyond store")
  `SSOC_ASSERT_NEXT(a_count_clear, s1_fire && s1_result, occ_total == '0, "count not cleared after text end")
  `SSOC_ASSERT_NEXT(a_no_lost_result, s1_valid && s1_result && !s1_fire, s1_valid && s1_result, "stalled result beat dropped")

endmodule

// ===== dv/ssoc_checker.sv =====
// Scoreboard for the substring occurrence counter: watches both channels,
// predicts each count from accepted input beats and compares result beats.
// Depends on ssoc_pkg, ssoc_in_if and ssoc_out_if.
module ssoc_checker (
  input  logic clk,
  input  logic rst,
  ssoc_in_if   item,
  ssoc_out_if  result,
  output int   fail_count,
  output int   pending
);
  import ssoc_pkg::*;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               saturated;
    logic               truncated;
  } tally_t;

  tally_t            expected_counts[$];
  logic [CHAR_W-1:0] pat_bytes [MAX_PATTERN];
  logic [CHAR_W-1:0] recent [MAX_PATTERN];  // entry 0 is the newest text byte
  int                pat_len;
  int                seen;
  logic [COUNT_W-1:0] total;
  logic              cut;
  logic              fresh;

  function automatic bit window_hit();
    if (pat_len == 0 || seen < pat_len) return 0;
    for (int k = 0; k < pat_len; k++) begin
      if (recent[k] != pat_bytes[pat_len-1-k]) return 0;
    end
    return 1;
  endfunction

  task automatic track_beat(input logic op, input logic [CHAR_W-1:0] ch, input logic fin);
    tally_t t;
    if (opcode_t'(op) == OP_PATTERN) begin
      if (fresh) begin
        pat_len = 0;
        cut     = 1'b0;
        fresh   = 1'b0;
      end
      if (pat_len < MAX_PATTERN) begin
        pat_bytes[pat_len] = ch;
        pat_len++;
      end else begin
        cut = 1'b1;
      end
      if (fin) fresh = 1'b1;
    end else begin
      // a text byte closes any open pattern as it stands
      fresh = 1'b1;
      for (int i = MAX_PATTERN - 1; i > 0; i--) recent[i] = recent[i-1];
      recent[0] = ch;
      if (seen < MAX_PATTERN) seen++;
      if (window_hit() && total != COUNT_MAX) total++;
      if (fin) begin
        t.count     = total;
        t.saturated = (total == COUNT_MAX);
        t.truncated = cut;
        expected_counts.push_back(t);
        total = '0;
        seen  = 0;
        foreach (recent[i]) recent[i] = '0;
      end
    end
  endtask

  task automatic check_field(input string what, input logic [COUNT_W-1:0] want,
                             input logic [COUNT_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    tally_t want;
    if (rst) begin
      expected_counts.delete();
      foreach (pat_bytes[i]) pat_bytes[i] = '0;
      foreach (recent[i]) recent[i] = '0;
      pat_len = 0;
      seen    = 0;
      total   = '0;
      cut     = 1'b0;
      fresh   = 1'b1;
    end else begin
      if (item.valid && item.ready) track_beat(item.opcode, item.char_value, item.last);
      if (result.valid && result.ready) begin
        if (expected_counts.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result beat, expected none, got count %0d sat %0b trunc %0b",
                   $time, result.match_count, result.count_saturated,
                   result.pattern_truncated);
        end else begin
          want = expected_counts.pop_front();
          check_field("match_count", want.count, result.match_count);
          check_field("count_saturated", COUNT_W'(want.saturated),
                      COUNT_W'(result.count_saturated));
          check_field("pattern_truncated", COUNT_W'(want.truncated),
                      COUNT_W'(result.pattern_truncated));
        end
      end
    end
    pending = expected_counts.size();
  end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the substring occurrence counter: clock, reset, stimulus
// and verdict. Depends on ssoc_pkg, both channel interfaces and ssoc_checker.
module tb;
  import ssoc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   beats_sent;
  bit   calm;  // no idling on either side while set
  logic [CHAR_W-1:0] pat_q[$];

  ssoc_in_if  item_ch();
  ssoc_out_if result_ch();

  substring_occurrence_counter i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  ssoc_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .item       (item_ch),
    .result     (result_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int pick_pause();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char(input bit narrow, input logic [CHAR_W-1:0] base);
    if (narrow) return base ^ CHAR_W'($urandom_range(0, 1));
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  task automatic send_beat(input opcode_t op, input logic [CHAR_W-1:0] ch, input logic fin);
    int gap;
    gap = pick_pause();
    repeat (gap) begin
      @(negedge clk);
      item_ch.valid <= 1'b0;
    end
    @(negedge clk);
    item_ch.valid      <= 1'b1;
    item_ch.opcode     <= op;
    item_ch.char_value <= ch;
    item_ch.last       <= fin;
    do @(posedge clk); while (!item_ch.ready);
    beats_sent++;
  endtask

  // hold off the input until every outstanding count has come back
  task automatic drain();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic load_pattern(input int len, input bit narrow, input logic [CHAR_W-1:0] base,
                              input bit close);
    logic [CHAR_W-1:0] ch;
    pat_q.delete();
    for (int i = 0; i < len; i++) begin
      ch = pick_char(narrow, base);
      pat_q.push_back(ch);
      send_beat(OP_PATTERN, ch, close && (i == len - 1));
    end
  endtask

  // text built from pattern copies and alphabet bytes, so hits are frequent
  task automatic stream_text(input int tlen, input bit narrow, input logic [CHAR_W-1:0] base);
    logic [CHAR_W-1:0] txt[$];
    int n;
    while (txt.size() < tlen) begin
      if (pat_q.size() != 0 && $urandom_range(0, 2) == 0) begin
        n = (pat_q.size() < MAX_PATTERN) ? pat_q.size() : MAX_PATTERN;
        for (int k = 0; k < n; k++) txt.push_back(pat_q[k]);
      end else begin
        txt.push_back(pick_char(narrow, base));
      end
    end
    foreach (txt[k]) send_beat(OP_TEXT, txt[k], k == txt.size() - 1);
  endtask

  initial begin : sink_pacing
    int hold;
    bit on;
    hold = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else begin
        if (calm) begin
          on = 1'b1;
        end else begin
          on   = ($urandom_range(0, 3) != 0);
          hold = on ? $urandom_range(0, 20) : pick_pause();
        end
        result_ch.ready <= on;
      end
    end
  end

  initial begin : stimulus
    int start;
    int r;
    int len;
    int tlen;
    bit narrow;
    logic [CHAR_W-1:0] base;
    item_ch.valid      = 1'b0;
    item_ch.opcode     = OP_PATTERN;
    item_ch.char_value = '0;
    item_ch.last       = 1'b0;
    calm       = 1'b0;
    beats_sent = 0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // no pattern since reset: nothing can match
    send_beat(OP_TEXT, 8'h61, 1'b0);
    send_beat(OP_TEXT, 8'h61, 1'b1);
    // overlapping hits
    send_beat(OP_PATTERN, 8'h61, 1'b0);
    send_beat(OP_PATTERN, 8'h61, 1'b1);
    repeat (3) send_beat(OP_TEXT, 8'h61, 1'b0);
    send_beat(OP_TEXT, 8'h61, 1'b1);
    // byte extremes
    send_beat(OP_PATTERN, 8'h00, 1'b0);
    send_beat(OP_PATTERN, 8'hFF, 1'b1);
    send_beat(OP_TEXT, 8'h00, 1'b0);
    send_beat(OP_TEXT, 8'hFF, 1'b0);
    send_beat(OP_TEXT, 8'h00, 1'b0);
    send_beat(OP_TEXT, 8'hFF, 1'b1);
    // text arrives while the pattern is still open
    send_beat(OP_PATTERN, 8'h80, 1'b0);
    send_beat(OP_TEXT, 8'h80, 1'b0);
    send_beat(OP_TEXT, 8'h80, 1'b1);
    // a pattern beat after text starts a new pattern
    send_beat(OP_PATTERN, 8'h7F, 1'b0);
    send_beat(OP_PATTERN, 8'h01, 1'b1);
    send_beat(OP_TEXT, 8'h7F, 1'b0);
    send_beat(OP_TEXT, 8'h01, 1'b0);
    send_beat(OP_TEXT, 8'h7F, 1'b0);
    send_beat(OP_TEXT, 8'h01, 1'b1);
    // pattern longer than the store; the dropped last beat still closes it
    load_pattern(MAX_PATTERN + 2, 1'b0, 8'h00, 1'b1);
    for (int k = 0; k < MAX_PATTERN; k++) send_beat(OP_TEXT, pat_q[k], k == MAX_PATTERN - 1);
    drain();

    // count overflow: one hit per beat past the saturation point
    calm = 1'b1;
    send_beat(OP_PATTERN, 8'h55, 1'b1);
    for (int k = 0; k < 65540; k++) send_beat(OP_TEXT, 8'h55, k == 65539);
    send_beat(OP_TEXT, 8'hAA, 1'b1);
    calm = 1'b0;
    drain();

    start = beats_sent;
    while (beats_sent - start < 1600) begin
      calm = ($urandom_range(0, 6) == 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6))
          send_beat(opcode_t'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
      end else begin
        narrow = ($urandom_range(0, 4) != 0);
        base   = CHAR_W'($urandom_range(0, 255));
        if ($urandom_range(0, 4) != 0) begin
          r = $urandom_range(0, 99);
          if (r < 70)      len = $urandom_range(1, 4);
          else if (r < 90) len = $urandom_range(5, 16);
          else if (r < 97) len = $urandom_range(MAX_PATTERN - 4, MAX_PATTERN);
          else             len = $urandom_range(MAX_PATTERN + 1, MAX_PATTERN + 6);
          load_pattern(len, narrow, base, $urandom_range(0, 19) != 0);
        end
        tlen = $urandom_range(1, 40);
        if (pat_q.size() > 8) tlen += pat_q.size();
        stream_text(tlen, narrow, base);
      end
      if ($urandom_range(0, 24) == 0) drain();
    end

    calm = 1'b0;
    drain();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/ssoc_pkg.sv
src/ssoc_in_if.sv
src/ssoc_out_if.sv
src/ssoc_pattern.sv
src/ssoc_window.sv
src/substring_occurrence_counter.sv
dv/ssoc_checker.sv
dv/tb.sv
